// ===== design/cyclic_partition_window_scheduler_unit_assert.svh =====
// assertion macros for the cyclic partition window scheduler
`ifndef CYCLIC_PARTITION_WINDOW_SCHEDULER_UNIT_ASSERT_SVH
`define CYCLIC_PARTITION_WINDOW_SCHEDULER_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, checked outside reset
`define CPWS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpws assertion failed");
// next-cycle implication, checked outside reset
`define CPWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpws assertion failed");
`else
`define CPWS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define CPWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/cpws_pkg.sv =====
`default_nettype none

package cpws_pkg;

  localparam int unsigned CORES     = 4;
  localparam int unsigned SLOTS     = 16;
  localparam int unsigned CORE_W    = 2;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CNT_W     = 5;
  localparam int unsigned ADDR_W    = CORE_W + SLOT_W;
  localparam int unsigned DEPTH     = CORES * SLOTS;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned PART_W    = 8;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_TICK = 1'b1
  } mode_e;

  typedef struct packed {
    logic [PART_W-1:0] partition;
    logic [TIME_W-1:0] offset;
    logic [TIME_W-1:0] duration;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } ram_rd_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } ram_wr_t;

  typedef struct packed {
    logic [CORE_W-1:0] core;
    logic [SLOT_W-1:0] slot;
    logic [PART_W-1:0] partition;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic              last;
  } result_t;

  typedef logic [CORES-1:0][CNT_W-1:0] slot_cnt_t;

endpackage

`default_nettype wire

// ===== design/cpws_entry_ram.sv =====
`default_nettype none

module cpws_entry_ram
  import cpws_pkg::*;
(
  input  wire logic    clk_i,
  input  wire ram_wr_t wr_i,
  input  wire ram_rd_t rd_i,
  output entry_t       rd_data_o
);

  // schedule table, one row per core and slot
  entry_t mem_q [DEPTH];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ===== design/cpws_sequencer.sv =====
`default_nettype none

`include "cyclic_partition_window_scheduler_unit_assert.svh"

module cpws_sequencer
  import cpws_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              tick_i,
  input  wire logic [TIME_W-1:0] now_i,
  input  wire slot_cnt_t         slot_cnt_i,
  output logic                   busy_o,
  output ram_rd_t                rd_o,
  input  wire entry_t            rd_data_i,
  output logic                   out_valid_o,
  output result_t                out_o
);

  // scan stage
  logic              scan_q;
  logic [CORE_W-1:0] core_q;
  logic              first_q;
  logic              started_q;
  logic [TIME_W-1:0] now_q;

  // per-core window state
  logic [CORES-1:0][SLOT_W-1:0] act_q;
  logic [CORES-1:0][TIME_W-1:0] wend_q;

  // read data stage
  logic              s1_v_q;
  logic [CORE_W-1:0] s1_core_q;
  logic [SLOT_W-1:0] s1_slot_q;

  // one result held back until it is known whether it is the last
  logic    pend_v_q;
  result_t pend_q;
  logic    out_v_q;
  result_t out_q;
  result_t out_d;

  logic [CNT_W-1:0]  cnt_raw;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  act_nx;
  logic [SLOT_W-1:0] next_slot;
  logic              due;
  logic              hit;
  logic              flush;
  result_t           s1_res;

  always_comb begin
    cnt_raw = slot_cnt_i[core_q];
    cnt     = (cnt_raw > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : cnt_raw;
    act_nx  = {1'b0, act_q[core_q]} + CNT_W'(1);
    if (first_q || (act_nx >= cnt)) begin
      next_slot = '0;
    end else begin
      next_slot = act_nx[SLOT_W-1:0];
    end
    due  = first_q || (now_q >= wend_q[core_q]);
    hit  = scan_q && (cnt != '0) && due;

    rd_o.en   = hit;
    rd_o.addr = {core_q, next_slot};

    s1_res.core       = s1_core_q;
    s1_res.slot       = s1_slot_q;
    s1_res.partition  = rd_data_i.partition;
    s1_res.start_time = now_q + rd_data_i.offset;
    s1_res.end_time   = now_q + rd_data_i.duration;
    s1_res.last       = 1'b0;

    flush = pend_v_q && !s1_v_q && !scan_q;

    out_d      = pend_q;
    out_d.last = flush;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q    <= 1'b0;
      core_q    <= '0;
      first_q   <= 1'b0;
      started_q <= 1'b0;
      act_q     <= '0;
      wend_q    <= '0;
      s1_v_q    <= 1'b0;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      if (tick_i) begin
        scan_q    <= 1'b1;
        core_q    <= '0;
        first_q   <= !started_q;
        started_q <= 1'b1;
      end else if (scan_q) begin
        core_q <= core_q + CORE_W'(1);
        if (core_q == CORE_W'(CORES - 1)) begin
          scan_q <= 1'b0;
        end
      end
      s1_v_q <= hit;
      if (s1_v_q) begin
        act_q[s1_core_q]  <= s1_slot_q;
        wend_q[s1_core_q] <= s1_res.end_time;
      end
      if (s1_v_q) begin
        pend_v_q <= 1'b1;
      end else if (flush) begin
        pend_v_q <= 1'b0;
      end
      out_v_q <= (s1_v_q && pend_v_q) || flush;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_i) begin
      now_q <= now_i;
    end
    s1_core_q <= core_q;
    s1_slot_q <= next_slot;
    if (s1_v_q) begin
      pend_q <= s1_res;
    end
    out_q <= out_d;
  end

  assign busy_o      = scan_q || s1_v_q || pend_v_q;
  assign out_valid_o = out_v_q;
  assign out_o       = out_q;

  `CPWS_ASSERT_NEXT(a_tick_scans, clk_i, rst_ni, tick_i, scan_q && (core_q == '0))
  `CPWS_ASSERT_IMPL(a_last_clears, clk_i, rst_ni, out_v_q && out_q.last, !busy_o)
  `CPWS_ASSERT_IMPL(a_more_follows, clk_i, rst_ni, out_v_q && !out_q.last, pend_v_q)

endmodule

`default_nettype wire

// ===== design/cyclic_partition_window_scheduler_unit.sv =====
// load word: writes one schedule table row, no result
// tick word: one core is checked per cycle, with a table read for each switching core
// results pass the read, held-back and output registers; the receiver cannot hold them off
// busy stays high after a tick, so the next word waits out the four-core scan,
// the table read and the held-back last result
// reset clears counts, window state and the started flag; the table is undefined until loaded
`default_nettype none

module cyclic_partition_window_scheduler_unit
  import cpws_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // command side
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic                 mode_i,
  input  wire logic [CORE_W-1:0]    core_i,
  input  wire logic [SLOT_W-1:0]    slot_i,
  input  wire logic [PART_W-1:0]    partition_id_i,
  input  wire logic [TIME_W-1:0]    offset_i,
  input  wire logic [TIME_W-1:0]    duration_i,
  input  wire logic [TIME_W-1:0]    now_i,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CNT_W-1:0]     cfg_data_i,
  // results, one-cycle strobe
  output logic                      out_valid_o,
  output logic [CORE_W-1:0]         out_core_o,
  output logic [SLOT_W-1:0]         out_slot_o,
  output logic [PART_W-1:0]         out_partition_o,
  output logic [TIME_W-1:0]         start_time_o,
  output logic [TIME_W-1:0]         end_time_o,
  output logic                      last_o
);

  // per-core slot counts
  slot_cnt_t slot_cnt_q;

  logic    accept;
  logic    tick;
  ram_wr_t wr;
  ram_rd_t rd;
  entry_t  rd_data;
  result_t res;

  // a word is taken whenever the sequencer is idle
  assign accept = start && !busy;
  assign tick   = accept && (mode_e'(mode_i) == MODE_TICK);

  // load words go straight into the table
  always_comb begin
    wr.en             = accept && (mode_e'(mode_i) == MODE_LOAD);
    wr.addr           = {core_i, slot_i};
    wr.data.partition = partition_id_i;
    wr.data.offset    = offset_i;
    wr.data.duration  = duration_i;
  end

  // configuration is always ready; indexes past the core count are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_cnt_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o && (cfg_index_i < CFG_IDX_W'(CORES))) begin
      slot_cnt_q[cfg_index_i[CORE_W-1:0]] <= cfg_data_i;
    end
  end

  cpws_entry_ram u_entry_ram (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  // scan, table read and result ordering
  cpws_sequencer u_sequencer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tick_i      (tick),
    .now_i       (now_i),
    .slot_cnt_i  (slot_cnt_q),
    .busy_o      (busy),
    .rd_o        (rd),
    .rd_data_i   (rd_data),
    .out_valid_o (out_valid_o),
    .out_o       (res)
  );

  assign out_core_o      = res.core;
  assign out_slot_o      = res.slot;
  assign out_partition_o = res.partition;
  assign start_time_o    = res.start_time;
  assign end_time_o      = res.end_time;
  assign last_o          = res.last;

endmodule

`default_nettype wire

// ===== sim/cyclic_partition_window_scheduler_unit_test.sv =====
`timescale 1ns / 1ps

module cyclic_partition_window_scheduler_unit_test;
  import cpws_pkg::*;

  localparam int SETTLE_CYCLES = 12;        // quiet cycles after the last accept before a count write goes out
  localparam int TIMEOUT_NS    = 2_000_000;
  localparam int REPORT_LIMIT  = 10;

  // one pending word: either a command (load or tick) or a count register write
  typedef struct {
    bit                   is_reg;
    bit                   no_idle;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CNT_W-1:0]     reg_val;
    mode_e                mode;
    logic [CORE_W-1:0]    core;
    logic [SLOT_W-1:0]    slot;
    logic [PART_W-1:0]    part;
    logic [TIME_W-1:0]    offset;
    logic [TIME_W-1:0]    duration;
    logic [TIME_W-1:0]    now;
  } sched_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // command side, all driven to known values from time zero
  logic                 start          = 1'b0;
  logic                 busy;
  logic                 mode_i         = MODE_LOAD;
  logic [CORE_W-1:0]    core_i         = '0;
  logic [SLOT_W-1:0]    slot_i         = '0;
  logic [PART_W-1:0]    partition_id_i = '0;
  logic [TIME_W-1:0]    offset_i       = '0;
  logic [TIME_W-1:0]    duration_i     = '0;
  logic [TIME_W-1:0]    now_i          = '0;
  // count register channel
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [CNT_W-1:0]     cfg_data_i     = '0;
  // result strobe
  logic                 out_valid_o;
  logic [CORE_W-1:0]    out_core_o;
  logic [SLOT_W-1:0]    out_slot_o;
  logic [PART_W-1:0]    out_partition_o;
  logic [TIME_W-1:0]    start_time_o;
  logic [TIME_W-1:0]    end_time_o;
  logic                 last_o;

  cyclic_partition_window_scheduler_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .core_i          (core_i),
    .slot_i          (slot_i),
    .partition_id_i  (partition_id_i),
    .offset_i        (offset_i),
    .duration_i      (duration_i),
    .now_i           (now_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_core_o      (out_core_o),
    .out_slot_o      (out_slot_o),
    .out_partition_o (out_partition_o),
    .start_time_o    (start_time_o),
    .end_time_o      (end_time_o),
    .last_o          (last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // words still to be driven, and window switches still to be reported
  sched_word_t word_backlog[$];
  result_t     switch_queue[$];

  // shadow copy of the scheduler: schedule table, per-core window state, counts
  logic [PART_W-1:0] tbl_part   [DEPTH];
  logic [TIME_W-1:0] tbl_off    [DEPTH];
  logic [TIME_W-1:0] tbl_dur    [DEPTH];
  logic [SLOT_W-1:0] cur_slot   [CORES];
  logic [TIME_W-1:0] win_end    [CORES];
  logic [CNT_W-1:0]  slot_limit [CORES];
  bit                sched_started;

  bit sequence_calm;  // words queued while set never get a random idle burst started in front of them
  int words_planned;
  int loads_done;
  int ticks_done;
  int regs_done;
  int switches_seen;
  int fault_count;

  // ---------------------------------------------------------------------------
  // window switch prediction for one accepted command word
  // ---------------------------------------------------------------------------
  task automatic advance_windows(input sched_word_t w);
    int          c;
    int          idx;
    int unsigned used;
    int unsigned nxt;
    int          n_sw;
    bit          first_tick;
    result_t     r;
    if (w.mode == MODE_LOAD) begin
      // table write, never a result
      idx = {w.core, w.slot};
      tbl_part[idx] = w.part;
      tbl_off[idx]  = w.offset;
      tbl_dur[idx]  = w.duration;
      return;
    end
    first_tick    = !sched_started;
    sched_started = 1'b1;
    n_sw          = 0;
    for (c = 0; c < CORES; c++) begin
      // counts above the table depth behave as a full table
      used = (slot_limit[c] > SLOTS) ? SLOTS : slot_limit[c];
      if (used == 0) continue;
      if (first_tick) begin
        nxt = 0;
      end else begin
        // plain unsigned compare, no wrap handling
        if (w.now < win_end[c]) continue;
        nxt = cur_slot[c] + 1;
        if (nxt >= used) nxt = 0;
      end
      idx          = c * SLOTS + nxt;
      cur_slot[c]  = SLOT_W'(nxt);
      win_end[c]   = w.now + tbl_dur[idx];
      r.core       = CORE_W'(c);
      r.slot       = SLOT_W'(nxt);
      r.partition  = tbl_part[idx];
      r.start_time = w.now + tbl_off[idx];
      r.end_time   = win_end[c];
      r.last       = 1'b0;
      switch_queue.push_back(r);
      n_sw++;
    end
    // the final switch of a tick carries the last flag
    if (n_sw > 0) begin
      r      = switch_queue.pop_back();
      r.last = 1'b1;
      switch_queue.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------------------
  task automatic queue_word(input mode_e m, input logic [CORE_W-1:0] c,
                            input logic [SLOT_W-1:0] s, input logic [PART_W-1:0] p,
                            input logic [TIME_W-1:0] o, input logic [TIME_W-1:0] d,
                            input logic [TIME_W-1:0] n);
    sched_word_t w;
    w.is_reg   = 1'b0;
    w.no_idle  = sequence_calm;
    w.reg_idx  = '0;
    w.reg_val  = '0;
    w.mode     = m;
    w.core     = c;
    w.slot     = s;
    w.part     = p;
    w.offset   = o;
    w.duration = d;
    w.now      = n;
    word_backlog.push_back(w);
    words_planned++;
  endtask

  task automatic queue_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
    sched_word_t w;
    w.is_reg   = 1'b1;
    w.no_idle  = sequence_calm;
    w.reg_idx  = idx;
    w.reg_val  = val;
    w.mode     = MODE_LOAD;
    w.core     = '0;
    w.slot     = '0;
    w.part     = '0;
    w.offset   = '0;
    w.duration = '0;
    w.now      = '0;
    word_backlog.push_back(w);
  endtask

  // mostly short windows so that switches stay frequent, sometimes huge or zero
  function automatic logic [TIME_W-1:0] pick_span();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel < 8) return TIME_W'($urandom_range(1, 60));
    return $urandom;
  endfunction

  // ---------------------------------------------------------------------------
  // driver: one word at a time from the backlog, predictions made on accept
  // ---------------------------------------------------------------------------
  sched_word_t cur_word;
  int          idle_left;
  int          quiet_cycles;

  always @(posedge clk_i) begin : driver
    int  k;
    bit  may_idle;
    if (!rst_ni) begin
      start        <= 1'b0;
      cfg_valid_i  <= 1'b0;
      idle_left     = 0;
      quiet_cycles  = 0;
      sched_started = 1'b0;
      for (k = 0; k < CORES; k++) begin
        cur_slot[k]   = '0;
        win_end[k]    = '0;
        slot_limit[k] = '0;
      end
    end else begin
      // handshakes that complete at this edge
      if (start && !busy) begin
        advance_windows(cur_word);
        quiet_cycles = 0;
        if (cur_word.mode == MODE_TICK) ticks_done++;
        else loads_done++;
      end else if (quiet_cycles < 1000) begin
        quiet_cycles++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        // indexes past the last core register are dropped
        if (cfg_index_i < CORES) slot_limit[cfg_index_i] = cfg_data_i;
        regs_done++;
      end

      may_idle = word_backlog.size() > 25 && !word_backlog[0].no_idle;
      if ((start && busy) || (cfg_valid_i && !cfg_ready_o)) begin
        // word still on offer, hold everything
      end else if (idle_left > 0) begin
        idle_left--;
        start       <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else if (word_backlog.size() == 0) begin
        start       <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else if (may_idle && $urandom_range(0, 3) == 0) begin
        // idle burst, starting with this cycle; idle_left holds the rest of it
        idle_left    = $urandom_range(0, 5);
        start       <= 1'b0;
        cfg_valid_i <= 1'b0;
      end else if (word_backlog[0].is_reg) begin
        // count writes only once every switch is out and the block has settled
        if (switch_queue.size() == 0 && quiet_cycles >= SETTLE_CYCLES && !busy) begin
          cur_word     = word_backlog.pop_front();
          cfg_index_i <= cur_word.reg_idx;
          cfg_data_i  <= cur_word.reg_val;
          cfg_valid_i <= 1'b1;
        end else begin
          cfg_valid_i <= 1'b0;
        end
        start <= 1'b0;
      end else begin
        cur_word        = word_backlog.pop_front();
        mode_i         <= cur_word.mode;
        core_i         <= cur_word.core;
        slot_i         <= cur_word.slot;
        partition_id_i <= cur_word.part;
        offset_i       <= cur_word.offset;
        duration_i     <= cur_word.duration;
        now_i          <= cur_word.now;
        start          <= 1'b1;
        cfg_valid_i    <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every strobed result against the oldest predicted switch
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    result_t want;
    result_t got;
    if (rst_ni && out_valid_o) begin
      got.core       = out_core_o;
      got.slot       = out_slot_o;
      got.partition  = out_partition_o;
      got.start_time = start_time_o;
      got.end_time   = end_time_o;
      got.last       = last_o;
      switches_seen++;
      if (switch_queue.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
          $display("%0t: unexpected switch core %0d slot %0d part %h start %h end %h last %b",
                   $time, got.core, got.slot, got.partition, got.start_time, got.end_time,
                   got.last);
      end else begin
        want = switch_queue.pop_front();
        if (got.core !== want.core || got.slot !== want.slot ||
            got.partition !== want.partition || got.start_time !== want.start_time ||
            got.end_time !== want.end_time || got.last !== want.last) begin
          fault_count++;
          if (fault_count <= REPORT_LIMIT) begin
            $display("%0t: switch mismatch", $time);
            $display("  expected core %0d slot %0d part %h start %h end %h last %b",
                     want.core, want.slot, want.partition, want.start_time, want.end_time,
                     want.last);
            $display("  actual   core %0d slot %0d part %h start %h end %h last %b",
                     got.core, got.slot, got.partition, got.start_time, got.end_time,
                     got.last);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [TIME_W-1:0] t;
    int                phase;
    int                len;
    int                i;
    int                k;
    int                sel;
    logic [CNT_W-1:0]  v;
    int                guard;

    sequence_calm = 1'b0;

    // first tick while every count is zero: nothing switches, scheduler marks itself started
    queue_word(MODE_TICK, 2'd3, 4'd15, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    // table rows with extreme contents; a row at the top slot that no count reaches yet
    queue_word(MODE_LOAD, 2'd0, 4'd0, 8'h00, 32'd0, 32'd0, 32'd0);
    queue_word(MODE_LOAD, 2'd0, 4'd1, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_word(MODE_LOAD, 2'd1, 4'd0, 8'hA5, 32'd3, 32'd20, 32'h5555_AAAA);
    queue_word(MODE_LOAD, 2'd2, 4'd0, 8'h11, 32'h8000_0000, 32'h10, 32'hAAAA_5555);
    queue_word(MODE_LOAD, 2'd3, 4'd15, 8'h3C, 32'h7FFF_FFFF, 32'd1, 32'd0);
    // counts only cover rows already written; two writes past the register list
    queue_reg(4'd0, 5'd2);
    queue_reg(4'd1, 5'd1);
    queue_reg(4'd2, 5'd1);
    queue_reg(4'd3, 5'd0);
    queue_reg(4'd15, 5'd31);
    queue_reg(4'd4, 5'd16);
    // cores gaining entries after the start advance from slot 0, or wrap on one entry
    queue_word(MODE_TICK, 2'd0, 4'd0, 8'h00, 32'd0, 32'd0, 32'd5);
    // wrapped end time, boundary equality and one tick short of a window end
    queue_word(MODE_TICK, 2'd1, 4'd5, 8'h5A, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 32'd4);
    queue_word(MODE_TICK, 2'd2, 4'd10, 8'hC3, 32'd0, 32'd0, 32'd4);
    queue_word(MODE_TICK, 2'd0, 4'd0, 8'h00, 32'd0, 32'd0, 32'd24);
    queue_word(MODE_TICK, 2'd0, 4'd0, 8'h00, 32'd0, 32'd0, 32'd25);
    // shrink core 0 below its active slot
    queue_reg(4'd0, 5'd1);
    queue_word(MODE_TICK, 2'd0, 4'd0, 8'h00, 32'd0, 32'd0, 32'hFFFF_FFF0);
    queue_word(MODE_TICK, 2'd0, 4'd0, 8'h00, 32'd0, 32'd0, 32'h0000_0010);

    // fill the whole table before any count can reach an unwritten row
    for (k = 0; k < DEPTH; k++)
      queue_word(MODE_LOAD, CORE_W'(k / SLOTS), SLOT_W'(k % SLOTS), PART_W'($urandom),
                 $urandom, pick_span(), $urandom);

    // phases: new counts, then mostly ticks on a moving clock with some reloads
    t     = 32'd100;
    phase = 0;
    while (words_planned < 180) begin
      sequence_calm = (phase % 3 == 2);
      for (k = 0; k < CORES; k++) begin
        case (phase)
          0: v = 5'd16;
          1: v = 5'd31;
          2: v = 5'd0;
          default: begin
            sel = $urandom_range(0, 9);
            if (sel == 0) v = 5'd0;
            else if (sel < 6) v = CNT_W'($urandom_range(1, 4));
            else if (sel < 9) v = CNT_W'($urandom_range(5, 16));
            else v = CNT_W'($urandom_range(17, 31));
          end
        endcase
        queue_reg(CFG_IDX_W'(k), v);
      end
      if ($urandom_range(0, 2) == 0)
        queue_reg(CFG_IDX_W'($urandom_range(CORES, 15)), CNT_W'($urandom));
      len = (phase == 2) ? 4 : $urandom_range(14, 24);
      for (i = 0; i < len; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          queue_word(MODE_LOAD, CORE_W'($urandom), SLOT_W'($urandom), PART_W'($urandom),
                     $urandom, pick_span(), $urandom);
        end else begin
          // time mostly creeps forward, now and then jumps anywhere
          if ($urandom_range(0, 11) == 0) t = $urandom;
          else t = t + TIME_W'($urandom_range(0, 40));
          queue_word(MODE_TICK, CORE_W'($urandom), SLOT_W'($urandom), PART_W'($urandom),
                     $urandom, $urandom, t);
        end
      end
      phase++;
    end
    sequence_calm = 1'b0;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // sample on the falling edge so driver updates have settled
    while (word_backlog.size() != 0 || start || cfg_valid_i) @(negedge clk_i);
    for (guard = 0; guard < 200 && switch_queue.size() != 0; guard++) @(negedge clk_i);
    repeat (16) @(negedge clk_i);
    if (switch_queue.size() != 0) begin
      $display("%0d predicted switches never reported", switch_queue.size());
      fault_count += switch_queue.size();
    end

    $display("covered %0d table loads, %0d ticks and %0d count writes over %0d phases",
             loads_done, ticks_done, regs_done, phase);
    $display("checked %0d window switches, %0d faults", switches_seen, fault_count);
    if (fault_count == 0) begin
      $display("[cyclic_partition_window_scheduler_unit] OK");
    end else begin
      $display("[cyclic_partition_window_scheduler_unit] ERROR");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("timeout with %0d words pending", word_backlog.size());
    $display("[cyclic_partition_window_scheduler_unit] ERROR");
    $finish;
  end

endmodule

// ===== cyclic_partition_window_scheduler_unit.f =====
+incdir+design
design/cpws_pkg.sv
design/cpws_entry_ram.sv
design/cpws_sequencer.sv
design/cyclic_partition_window_scheduler_unit.sv
sim/cyclic_partition_window_scheduler_unit_test.sv
